// ----- hdl/stereo_track_mixer_balance_pan_core_defines.svh -----
// ----------------------------------------------------------------------------
// Stereo track mixer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STEREO_TRACK_MIXER_BALANCE_PAN_CORE_DEFINES_SVH
`define STEREO_TRACK_MIXER_BALANCE_PAN_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define STMBP_ASSERT_SAME(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error(msg);
`define STMBP_ASSERT_NEXT(name, clk, rstn, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error(msg);
`else
`define STMBP_ASSERT_SAME(name, clk, rstn, pre, post, msg)
`define STMBP_ASSERT_NEXT(name, clk, rstn, pre, post, msg)
`endif

`endif

// ----- hdl/stmbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer package
// Widths, pipeline stage indexes, stage enable struct and the cosine table.
// ----------------------------------------------------------------------------
package stmbp_pkg;

    localparam int TRACKS          = 4;
    localparam int MAX_TRACKS      = 4;
    localparam int COS_TABLE_DEPTH = 256;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int PAN_W      = 16;
    localparam int MAG_W      = 15;
    localparam int FRAC_W     = 14;
    localparam int COS_W      = 16;
    localparam int IDX_W      = $clog2(COS_TABLE_DEPTH + 1);
    localparam int POS_W      = FRAC_W + 1 + IDX_W;
    localparam int COEF_W     = GAIN_W + COS_W;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int Q_SHIFT    = FRAC_W + SAMPLE_W - 1;
    localparam int RND_W      = ACC_W - Q_SHIFT;

    localparam int IN_DATA_W  = 2 * SAMPLE_W * MAX_TRACKS;
    localparam int IN_USER_W  = MAX_TRACKS;
    localparam int OUT_DATA_W = 2 * SAMPLE_W;

    localparam int CFG_IDX_W  = $clog2(2 * TRACKS);
    localparam int CFG_ADDR_W = CFG_IDX_W + 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;
    localparam logic [PAN_W-1:0]  PAN_RESET  = 16'd0;
    localparam logic [COS_W-1:0]  COS_ONE    = 16'd32768;

    // pipeline stages
    localparam int ST_LOOKUP  = 0;
    localparam int ST_INTERP  = 1;
    localparam int ST_COEF    = 2;
    localparam int ST_PROD    = 3;
    localparam int ST_SUM     = 4;
    localparam int ST_OUT     = 5;
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic lookup;
        logic interp;
        logic coef;
        logic prod;
        logic sum;
        logic out;
    } stmbp_stage_en_t;

    typedef logic [TRACKS-1:0][GAIN_W-1:0] gain_arr_t;
    typedef logic [TRACKS-1:0][PAN_W-1:0]  pan_arr_t;
    typedef logic [TRACKS-1:0][PROD_W-1:0] prod_arr_t;

    typedef logic [COS_W-1:0] cos_tab_t [0:COS_TABLE_DEPTH];

    localparam longint Q30_ONE     = 64'sd1 << 30;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    // cos over [0, pi/2] in Q1.15, Taylor series in Q30, rounded to nearest
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t tab;
        longint   x;
        longint   x2;
        longint   t;
        longint   c;
        int       k;
        for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x  = (Q30_HALF_PI * longint'(k)) / COS_TABLE_DEPTH;
            x2 = (x * x) >>> 30;
            t  = Q30_ONE;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 182;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 132;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 90;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 56;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 30;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 12;
            t  = Q30_ONE - ((x2 * t) / Q30_ONE) / 2;
            if (t < 0) begin
                t = 0;
            end
            c      = (t + (64'sd1 << 14)) >>> 15;
            tab[k] = c[COS_W-1:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

// ----- hdl/stereo_track_mixer_balance_pan_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer with balance-law pan
// Four-track stereo mixer, per-track gain and pan, saturated Q1.15 output.
// ----------------------------------------------------------------------------
// Takes one frame per clock unless m_tready stalls the output. One lane per
// track does the pan cosine lookup, interpolation, gain and sample products
// in four registered stages, and a merge unit sums and rounds in two more.
// Each stage holds its frame only while the next one is full, so a frame is
// accepted while a finished result waits at m_tdata and up to six frames are
// in flight. Gains and pans sit at byte addresses 0x00..0x0C and 0x10..0x1C;
// the user must write them between frames, as the block does not enforce it.
`include "stereo_track_mixer_balance_pan_core_defines.svh"

module stereo_track_mixer_balance_pan_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // APB-style configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [stmbp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [stmbp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [stmbp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    // input frames
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // t0_left, t0_right, t1_left, t1_right, t2_left, t2_right, t3_left, t3_right
    input  logic [stmbp_pkg::IN_DATA_W-1:0]  s_tdata,
    // active_mask
    input  logic [stmbp_pkg::IN_USER_W-1:0]  s_tuser,
    // mixed output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mix_left, mix_right
    output logic [stmbp_pkg::OUT_DATA_W-1:0] m_tdata
);
    import stmbp_pkg::*;

    gain_arr_t               gain;
    pan_arr_t                pan;
    prod_arr_t               prod_left;
    prod_arr_t               prod_right;
    logic [SAMPLE_W-1:0]     mix_left;
    logic [SAMPLE_W-1:0]     mix_right;

    logic [NUM_STAGES-1:0]   valid_reg;
    logic [NUM_STAGES-1:0]   valid_next;
    logic [NUM_STAGES-1:0]   stage_rdy;
    logic [NUM_STAGES-1:0]   stage_in;
    logic [NUM_STAGES-1:0]   stage_ld;
    stmbp_stage_en_t         stage_en;

    stmbp_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gain    (gain),
        .pan     (pan)
    );

    // pipeline occupancy and per-stage ready
    always_comb begin
        stage_rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        stage_in[0] = s_tvalid;
        for (int i = 1; i < NUM_STAGES; i++) begin
            stage_in[i] = valid_reg[i-1];
        end
        for (int i = 0; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_rdy[i] ? stage_in[i] : valid_reg[i];
            stage_ld[i]   = stage_rdy[i] && stage_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign stage_en.lookup = stage_ld[ST_LOOKUP];
    assign stage_en.interp = stage_ld[ST_INTERP];
    assign stage_en.coef   = stage_ld[ST_COEF];
    assign stage_en.prod   = stage_ld[ST_PROD];
    assign stage_en.sum    = stage_ld[ST_SUM];
    assign stage_en.out    = stage_ld[ST_OUT];

    genvar k;
    generate
        for (k = 0; k < TRACKS; k++) begin : g_lane
            stmbp_lane u_lane (
                .aclk         (aclk),
                .stage_en     (stage_en),
                .gain         (gain[k]),
                .pan          ($signed(pan[k])),
                .sample_left  ($signed(s_tdata[2*SAMPLE_W*k +: SAMPLE_W])),
                .sample_right ($signed(s_tdata[2*SAMPLE_W*k + SAMPLE_W +: SAMPLE_W])),
                .active       (s_tuser[k]),
                .prod_left    (prod_left[k]),
                .prod_right   (prod_right[k])
            );
        end
    endgenerate

    stmbp_merge u_merge (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .prod_left  (prod_left),
        .prod_right (prod_right),
        .mix_left   (mix_left),
        .mix_right  (mix_right)
    );

    assign s_tready = stage_rdy[ST_LOOKUP];
    assign m_tvalid = valid_reg[ST_OUT];
    assign m_tdata  = {mix_right, mix_left};

    `STMBP_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_tvalid && s_tready, valid_reg[ST_LOOKUP], "accepted transaction did not enter the pipeline")
    `STMBP_ASSERT_NEXT(a_prod_holds, aclk, aresetn, valid_reg[ST_PROD] && !stage_rdy[ST_SUM], valid_reg[ST_PROD], "stalled product stage lost its transaction")
    `STMBP_ASSERT_SAME(a_ready_when_drained, aclk, aresetn, !m_tvalid, s_tready, "input stalled with no result pending")

endmodule

// ----- hdl/stmbp_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer configuration registers
// APB-style register file holding per-track gain and pan.
// ----------------------------------------------------------------------------
module stmbp_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [stmbp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [stmbp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [stmbp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                             pready,
    output stmbp_pkg::gain_arr_t             gain,
    output stmbp_pkg::pan_arr_t              pan
);
    import stmbp_pkg::*;

    gain_arr_t              gain_reg;
    gain_arr_t              gain_next;
    pan_arr_t               pan_reg;
    pan_arr_t               pan_next;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb begin
        gain_next = gain_reg;
        pan_next  = pan_reg;
        prdata    = '0;
        for (int k = 0; k < TRACKS; k++) begin
            if (reg_idx == CFG_IDX_W'(k)) begin
                prdata = CFG_DATA_W'(gain_reg[k]);
                if (wr_en) begin
                    gain_next[k] = pwdata[GAIN_W-1:0];
                end
            end
            if (reg_idx == CFG_IDX_W'(TRACKS + k)) begin
                prdata = CFG_DATA_W'(pan_reg[k]);
                if (wr_en) begin
                    pan_next[k] = pwdata[PAN_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TRACKS; k++) begin
                gain_reg[k] <= GAIN_RESET;
                pan_reg[k]  <= PAN_RESET;
            end
        end else begin
            gain_reg <= gain_next;
            pan_reg  <= pan_next;
        end
    end

    assign gain = gain_reg;
    assign pan  = pan_reg;

endmodule

// ----- hdl/stmbp_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer lane
// One track: pan cosine lookup, interpolation, side coefficients, products.
// ----------------------------------------------------------------------------
module stmbp_lane (
    input  logic                                 aclk,
    input  stmbp_pkg::stmbp_stage_en_t           stage_en,
    input  logic        [stmbp_pkg::GAIN_W-1:0]  gain,
    input  logic signed [stmbp_pkg::PAN_W-1:0]   pan,
    input  logic signed [stmbp_pkg::SAMPLE_W-1:0] sample_left,
    input  logic signed [stmbp_pkg::SAMPLE_W-1:0] sample_right,
    input  logic                                 active,
    output logic        [stmbp_pkg::PROD_W-1:0]  prod_left,
    output logic        [stmbp_pkg::PROD_W-1:0]  prod_right
);
    import stmbp_pkg::*;

    localparam logic signed [PAN_W-1:0] PAN_MAX = 16'sd16384;
    localparam logic signed [PAN_W-1:0] PAN_MIN = -16'sd16384;
    localparam int RAMP_W = COS_W + FRAC_W + 1;

    // lookup
    logic signed [PAN_W-1:0]    pan_sat;
    logic [MAG_W-1:0]           pan_mag;
    logic [POS_W-1:0]           pos_val;
    logic [IDX_W:0]             idx_full;
    logic [IDX_W-1:0]           lo_idx;
    logic [IDX_W-1:0]           hi_idx;

    logic [COS_W-1:0]           lo_reg;
    logic [COS_W-1:0]           hi_reg;
    logic [FRAC_W-1:0]          frac_reg;
    logic                       att_left1_reg;
    logic                       att_right1_reg;
    logic [GAIN_W-1:0]          gain1_reg;
    logic signed [SAMPLE_W-1:0] left1_reg;
    logic signed [SAMPLE_W-1:0] right1_reg;
    logic                       act1_reg;

    // interpolation
    logic                       down;
    logic [COS_W-1:0]           delta;
    logic [RAMP_W-1:0]          ramp;
    logic [COS_W-1:0]           step;
    logic [COS_W-1:0]           cos_val;

    logic [COS_W-1:0]           cos_left_reg;
    logic [COS_W-1:0]           cos_right_reg;
    logic [GAIN_W-1:0]          gain2_reg;
    logic signed [SAMPLE_W-1:0] left2_reg;
    logic signed [SAMPLE_W-1:0] right2_reg;
    logic                       act2_reg;

    // coefficients
    logic [COEF_W-1:0]          coef_left_reg;
    logic [COEF_W-1:0]          coef_right_reg;
    logic signed [SAMPLE_W-1:0] left3_reg;
    logic signed [SAMPLE_W-1:0] right3_reg;
    logic                       act3_reg;

    // products
    logic signed [PROD_W-1:0]   prod_left_next;
    logic signed [PROD_W-1:0]   prod_right_next;
    logic [PROD_W-1:0]          prod_left_reg;
    logic [PROD_W-1:0]          prod_right_reg;

    always_comb begin
        if (pan > PAN_MAX) begin
            pan_sat = PAN_MAX;
        end else if (pan < PAN_MIN) begin
            pan_sat = PAN_MIN;
        end else begin
            pan_sat = pan;
        end
        pan_mag  = pan_sat[PAN_W-1] ? MAG_W'(-pan_sat) : MAG_W'(pan_sat);
        pos_val  = POS_W'(pan_mag) * POS_W'(COS_TABLE_DEPTH);
        idx_full = pos_val[POS_W-1:FRAC_W];
        if (idx_full >= (IDX_W+1)'(COS_TABLE_DEPTH)) begin
            lo_idx = IDX_W'(COS_TABLE_DEPTH);
            hi_idx = IDX_W'(COS_TABLE_DEPTH);
        end else begin
            lo_idx = idx_full[IDX_W-1:0];
            hi_idx = idx_full[IDX_W-1:0] + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.lookup) begin
            lo_reg         <= COS_TAB[lo_idx];
            hi_reg         <= COS_TAB[hi_idx];
            frac_reg       <= pos_val[FRAC_W-1:0];
            att_left1_reg  <= (pan_sat > 16'sd0);
            att_right1_reg <= (pan_sat < 16'sd0);
            gain1_reg      <= gain;
            left1_reg      <= sample_left;
            right1_reg     <= sample_right;
            act1_reg       <= active;
        end
    end

    always_comb begin
        down    = (lo_reg >= hi_reg);
        delta   = down ? (lo_reg - hi_reg) : (hi_reg - lo_reg);
        ramp    = RAMP_W'(delta) * RAMP_W'(frac_reg) + RAMP_W'(1 << (FRAC_W - 1));
        step    = ramp[COS_W+FRAC_W-1:FRAC_W];
        cos_val = down ? (lo_reg - step) : (lo_reg + step);
    end

    always_ff @(posedge aclk) begin
        if (stage_en.interp) begin
            cos_left_reg  <= att_left1_reg  ? cos_val : COS_ONE;
            cos_right_reg <= att_right1_reg ? cos_val : COS_ONE;
            gain2_reg     <= gain1_reg;
            left2_reg     <= left1_reg;
            right2_reg    <= right1_reg;
            act2_reg      <= act1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.coef) begin
            coef_left_reg  <= COEF_W'(gain2_reg) * COEF_W'(cos_left_reg);
            coef_right_reg <= COEF_W'(gain2_reg) * COEF_W'(cos_right_reg);
            left3_reg      <= left2_reg;
            right3_reg     <= right2_reg;
            act3_reg       <= act2_reg;
        end
    end

    always_comb begin
        prod_left_next  = left3_reg  * $signed({1'b0, coef_left_reg});
        prod_right_next = right3_reg * $signed({1'b0, coef_right_reg});
    end

    always_ff @(posedge aclk) begin
        if (stage_en.prod) begin
            prod_left_reg  <= act3_reg ? prod_left_next  : '0;
            prod_right_reg <= act3_reg ? prod_right_next : '0;
        end
    end

    assign prod_left  = prod_left_reg;
    assign prod_right = prod_right_reg;

endmodule

// ----- hdl/stmbp_merge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer merge
// Sums the lane products per side, rounds to Q1.15 and saturates.
// ----------------------------------------------------------------------------
module stmbp_merge (
    input  logic                                aclk,
    input  stmbp_pkg::stmbp_stage_en_t          stage_en,
    input  stmbp_pkg::prod_arr_t                prod_left,
    input  stmbp_pkg::prod_arr_t                prod_right,
    output logic [stmbp_pkg::SAMPLE_W-1:0]      mix_left,
    output logic [stmbp_pkg::SAMPLE_W-1:0]      mix_right
);
    import stmbp_pkg::*;

    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO = -RND_W'(32768);
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (Q_SHIFT - 1);

    logic signed [ACC_W-1:0]    sum_left;
    logic signed [ACC_W-1:0]    sum_right;
    logic signed [ACC_W-1:0]    acc_left_reg;
    logic signed [ACC_W-1:0]    acc_right_reg;
    logic signed [ACC_W-1:0]    biased_left;
    logic signed [ACC_W-1:0]    biased_right;
    logic signed [RND_W-1:0]    rnd_left;
    logic signed [RND_W-1:0]    rnd_right;
    logic [SAMPLE_W-1:0]        sat_left;
    logic [SAMPLE_W-1:0]        sat_right;
    logic [SAMPLE_W-1:0]        mix_left_reg;
    logic [SAMPLE_W-1:0]        mix_right_reg;

    always_comb begin
        sum_left  = '0;
        sum_right = '0;
        for (int k = 0; k < TRACKS; k++) begin
            sum_left  = sum_left  + ACC_W'($signed(prod_left[k]));
            sum_right = sum_right + ACC_W'($signed(prod_right[k]));
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.sum) begin
            acc_left_reg  <= sum_left;
            acc_right_reg <= sum_right;
        end
    end

    always_comb begin
        biased_left  = acc_left_reg  + ROUND_BIAS;
        biased_right = acc_right_reg + ROUND_BIAS;
        rnd_left     = RND_W'(biased_left  >>> Q_SHIFT);
        rnd_right    = RND_W'(biased_right >>> Q_SHIFT);
        if (rnd_left > SAT_HI) begin
            sat_left = SAT_HI[SAMPLE_W-1:0];
        end else if (rnd_left < SAT_LO) begin
            sat_left = SAT_LO[SAMPLE_W-1:0];
        end else begin
            sat_left = rnd_left[SAMPLE_W-1:0];
        end
        if (rnd_right > SAT_HI) begin
            sat_right = SAT_HI[SAMPLE_W-1:0];
        end else if (rnd_right < SAT_LO) begin
            sat_right = SAT_LO[SAMPLE_W-1:0];
        end else begin
            sat_right = rnd_right[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en.out) begin
            mix_left_reg  <= sat_left;
            mix_right_reg <= sat_right;
        end
    end

    assign mix_left  = mix_left_reg;
    assign mix_right = mix_right_reg;

endmodule

// ----- tb/stereo_track_mixer_balance_pan_core_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stereo track mixer testbench
// Drives frames and register writes into the four-track balance-pan mixer,
// computes every mix from its own cosine table and pan law, and checks each
// output transaction in order under several stream pacing modes.
// ----------------------------------------------------------------------------
module stereo_track_mixer_balance_pan_core_test;

    localparam int ADDR_W  = stmbp_pkg::CFG_ADDR_W;
    localparam int N_TRK   = stmbp_pkg::MAX_TRACKS;
    localparam int COS_PTS = stmbp_pkg::COS_TABLE_DEPTH;

    typedef enum int {
        REG_GAIN0 = 0, REG_GAIN1, REG_GAIN2, REG_GAIN3,
        REG_PAN0, REG_PAN1, REG_PAN2, REG_PAN3
    } mix_reg_t;

    typedef struct packed {
        logic [stmbp_pkg::IN_USER_W-1:0]                        active;
        logic [2*N_TRK-1:0][stmbp_pkg::SAMPLE_W-1:0]            smp;
    } frame_t;

    typedef struct packed {
        logic [stmbp_pkg::SAMPLE_W-1:0] right;
        logic [stmbp_pkg::SAMPLE_W-1:0] left;
    } mix_t;

    logic                                 aclk;
    logic                                 aresetn;
    logic                                 psel;
    logic                                 penable;
    logic                                 pwrite;
    logic [ADDR_W-1:0]                    paddr;
    logic [stmbp_pkg::CFG_DATA_W-1:0]     pwdata;
    logic [stmbp_pkg::CFG_DATA_W-1:0]     prdata;
    logic                                 pready;
    logic                                 s_tvalid;
    logic                                 s_tready;
    // t0_left, t0_right, t1_left, t1_right, t2_left, t2_right, t3_left, t3_right
    logic [stmbp_pkg::IN_DATA_W-1:0]      s_tdata;
    // active_mask
    logic [stmbp_pkg::IN_USER_W-1:0]      s_tuser;
    logic                                 m_tvalid;
    logic                                 m_tready;
    // mix_left, mix_right
    logic [stmbp_pkg::OUT_DATA_W-1:0]     m_tdata;

    // register mirror and cosine table of the predictor
    logic [15:0]        gain_set [N_TRK];
    logic signed [15:0] pan_set  [N_TRK];
    longint             cos_q15_tab [0:COS_PTS];

    mix_t   expected_mix [$];
    int     err_count      = 0;
    int     frames_checked = 0;
    int     settings_count = 0;
    int     send_idle_pct  = 0;
    int     recv_stall_pct = 0;

    stereo_track_mixer_balance_pan_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d mixes outstanding", expected_mix.size());
        $display("stereo_track_mixer_balance_pan_core_test: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    // cos over [0, pi/2], Q30 Taylor series, rounded to Q1.15
    function automatic void build_cos_table();
        longint divs [7] = '{182, 132, 90, 56, 30, 12, 2};
        longint x;
        longint x2;
        longint t;
        for (int k = 0; k <= COS_PTS; k++) begin
            x  = (64'sd1686629713 * k) / COS_PTS;
            x2 = (x * x) >>> 30;
            t  = 64'sd1 <<< 30;
            for (int i = 0; i < 7; i++) begin
                t = (64'sd1 <<< 30) - ((x2 * t) / (64'sd1 <<< 30)) / divs[i];
            end
            if (t < 0) begin
                t = 0;
            end
            cos_q15_tab[k] = (t + (64'sd1 <<< 14)) / (64'sd1 <<< 15);
        end
    endfunction

    // cos(mag * pi / 2), mag in Q2.14 within [0, 1]
    function automatic longint pan_cos(longint mag);
        longint pos;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        pos  = mag * COS_PTS;
        idx  = pos >>> 14;
        frac = pos & 64'h3FFF;
        if (idx >= COS_PTS) begin
            return cos_q15_tab[COS_PTS];
        end
        lo = cos_q15_tab[idx];
        hi = cos_q15_tab[idx + 1];
        if (lo >= hi) begin
            return lo - (((lo - hi) * frac + 8192) >>> 14);
        end
        return lo + (((hi - lo) * frac + 8192) >>> 14);
    endfunction

    function automatic logic [15:0] round_q15(longint acc);
        longint r;
        r = (acc + (64'sd1 <<< 28)) >>> 29;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r[15:0];
    endfunction

    function automatic mix_t mix_frame(frame_t f);
        longint acc_l;
        longint acc_r;
        longint p;
        longint cl;
        longint cr;
        mix_t   m;
        acc_l = 0;
        acc_r = 0;
        for (int k = 0; k < N_TRK; k++) begin
            if (f.active[k]) begin
                p  = longint'(pan_set[k]);
                cl = 32768;
                cr = 32768;
                if (p > 16384) begin
                    p = 16384;
                end else if (p < -16384) begin
                    p = -16384;
                end
                if (p < 0) begin
                    cr = pan_cos(-p);
                end else if (p > 0) begin
                    cl = pan_cos(p);
                end
                acc_l += longint'($signed(f.smp[2*k]))     * (longint'(gain_set[k]) * cl);
                acc_r += longint'($signed(f.smp[2*k + 1])) * (longint'(gain_set[k]) * cr);
            end
        end
        m.left  = round_q15(acc_l);
        m.right = round_q15(acc_r);
        return m;
    endfunction

    // ------------------------------------------------------------------
    // monitors and checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        err_count++;
        if (err_count <= 30) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin : frame_monitor
        if (aresetn && s_tvalid === 1'b1 && s_tready === 1'b1) begin
            expected_mix.insert(expected_mix.size(), mix_frame({s_tuser, s_tdata}));
        end
    end

    always @(posedge aclk) begin : mix_checker
        mix_t want;
        mix_t got;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata;
            if (expected_mix.size() == 0) begin
                report_mismatch($sformatf("mix %h with no frame outstanding", m_tdata));
            end else begin
                want = expected_mix.pop_front();
                frames_checked++;
                if (got.left !== want.left) begin
                    report_mismatch($sformatf("mix %0d left %h, want %h",
                                              frames_checked, got.left, want.left));
                end
                if (got.right !== want.right) begin
                    report_mismatch($sformatf("mix %0d right %h, want %h",
                                              frames_checked, got.right, want.right));
                end
            end
        end
    end

    // output backpressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_frame(input frame_t f);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= f.smp;
        s_tuser  <= f.active;
        do @(posedge aclk); while (s_tready !== 1'b1);
    endtask

    // let the monitor record the last transaction before looking at the queue
    task automatic wait_mix_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (expected_mix.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
    endtask

    // write, then read back in the next transaction
    task automatic cfg_write(input mix_reg_t r, input logic [15:0] val);
        logic [31:0] rd;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(r));
        pwdata  <= {16'h0000, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (r < REG_PAN0) begin
            gain_set[int'(r)] = val;
        end else begin
            pan_set[int'(r) - int'(REG_PAN0)] = val;
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[15:0] !== val) begin
            report_mismatch($sformatf("register %s reads %h, wrote %h", r.name(), rd, val));
        end
    endtask

    task automatic set_track(input int k, input logic [15:0] gain, input logic [15:0] pan);
        cfg_write(mix_reg_t'(int'(REG_GAIN0) + k), gain);
        cfg_write(mix_reg_t'(int'(REG_PAN0) + k), pan);
    endtask

    function automatic frame_t random_frame();
        frame_t f;
        for (int i = 0; i < 2 * N_TRK; i++) begin
            case ($urandom_range(15))
                0:       f.smp[i] = 16'h7FFF;
                1:       f.smp[i] = 16'h8000;
                2:       f.smp[i] = 16'h0000;
                default: f.smp[i] = 16'($urandom);
            endcase
        end
        f.active = 4'($urandom_range(15));
        return f;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        frame_t f;
        settings_count++;
        f.active = 4'hF;
        f.smp    = '0;
        send_frame(f);
        f.smp    = {2*N_TRK{16'h7FFF}};
        send_frame(f);
        f.smp    = {2*N_TRK{16'h8000}};
        send_frame(f);
        f.active = 4'h0;
        send_frame(f);
        f.active = 4'h1;
        f.smp    = {{2*N_TRK-2{16'h1234}}, 16'h8000, 16'h7FFF};
        send_frame(f);
        wait_mix_drained();
    endtask

    task automatic test_track_masks();
        frame_t f;
        for (int k = 0; k < N_TRK; k++) begin
            f        = random_frame();
            f.active = 4'b0001 << k;
            send_frame(f);
        end
        wait_mix_drained();
    endtask

    task automatic test_gain_extremes();
        set_track(0, 16'd0, 16'd0);
        set_track(1, 16'hFFFF, 16'd0);
        set_track(2, 16'd1, 16'd0);
        set_track(3, 16'd16384, 16'd0);
        settings_count++;
        send_frame({4'hF, {2*N_TRK{16'h4000}}});
        send_frame({4'hF, {2*N_TRK{16'hC001}}});
        wait_mix_drained();
    endtask

    task automatic test_pan_law();
        frame_t f;
        set_track(0, 16'd16384, 16'hC000);
        set_track(1, 16'd16384, 16'h4000);
        set_track(2, 16'd16384, 16'h7FFF);
        set_track(3, 16'd16384, 16'h8000);
        settings_count++;
        f = random_frame();
        f.active = 4'hF;
        send_frame(f);
        send_frame({4'hF, {2*N_TRK{16'h2000}}});
        wait_mix_drained();
        set_track(0, 16'd20000, 16'h2000);
        set_track(1, 16'd20000, 16'hE000);
        set_track(2, 16'd20000, 16'h0001);
        set_track(3, 16'd20000, 16'hFFFF);
        settings_count++;
        f = random_frame();
        f.active = 4'hF;
        send_frame(f);
        send_frame({4'hF, {2*N_TRK{16'h7FFF}}});
        wait_mix_drained();
    endtask

    task automatic test_saturation();
        for (int k = 0; k < N_TRK; k++) begin
            set_track(k, 16'hFFFF, 16'd0);
        end
        settings_count++;
        send_frame({4'hF, {N_TRK{16'h8000, 16'h7FFF}}});
        send_frame({4'h3, {N_TRK{16'h2000, 16'hE000}}});
        wait_mix_drained();
    endtask

    task automatic test_random_mix(input int n_frames);
        logic [15:0] gain;
        logic [15:0] pan;
        for (int k = 0; k < N_TRK; k++) begin
            case ($urandom_range(7))
                0:       gain = 16'd0;
                1:       gain = 16'hFFFF;
                2:       gain = 16'd16384;
                default: gain = 16'($urandom_range(65535));
            endcase
            case ($urandom_range(9))
                0:       pan = 16'd0;
                1:       pan = 16'h4000;
                2:       pan = 16'hC000;
                3:       pan = 16'($urandom);
                default: pan = 16'($urandom_range(32768) - 16384);
            endcase
            set_track(k, gain, pan);
        end
        settings_count++;
        repeat (n_frames) send_frame(random_frame());
        wait_mix_drained();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int limit;
        int idle_modes [4][2];
        idle_modes = '{'{0, 0}, '{63, 0}, '{0, 63}, '{34, 34}};
        build_cos_table();
        for (int k = 0; k < N_TRK; k++) begin
            gain_set[k] = 16'd16384;
            pan_set[k]  = 16'sd0;
        end
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        m_tready <= 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_track_masks();
        test_gain_extremes();
        test_pan_law();
        test_saturation();
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_modes[ph][0];
            recv_stall_pct = idle_modes[ph][1];
            repeat (4) test_random_mix(88);
        end

        s_tvalid <= 1'b0;
        limit = 0;
        while (expected_mix.size() != 0 && limit < 100000) begin
            @(posedge aclk);
            limit++;
        end
        repeat (20) @(posedge aclk);
        if (expected_mix.size() != 0) begin
            report_mismatch($sformatf("%0d mixes never arrived", expected_mix.size()));
        end
        $display("checked %0d mixed frames over %0d gain/pan settings", frames_checked,
                 settings_count);
        $display("pacing: free run, idle source, stalled sink, both; %0d mismatches",
                 err_count);
        if (err_count == 0) begin
            $display("stereo_track_mixer_balance_pan_core_test: PASS");
        end else begin
            $display("stereo_track_mixer_balance_pan_core_test: FAIL");
        end
        $finish;
    end

endmodule
